[sv/jpegls_run_mode_decoder_top_assert.svh]
// Assertion macros for the run-mode decoder.
`ifndef JPEGLS_RUN_MODE_DECODER_TOP_ASSERT_SVH
`define JPEGLS_RUN_MODE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JRMD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jrmd assertion failed");

// Next-cycle implication, checked outside reset.
`define JRMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jrmd assertion failed");

`endif

[sv/jrmd_pkg.sv]
// Shared types, codes and tables of the run-mode decoder.
package jrmd_pkg;

  localparam int unsigned LINE_MAX  = 4096;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 3;

  // Item operations
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BIT   = 2'd1;
  localparam logic [1:0] OP_ABOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_REQ    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QBPP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RTHR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AINIT  = 3'd6;

  // Decoding phase of the current run
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_RUN   = 7'b0000010,
    PH_REM   = 7'b0000100,
    PH_WAIT  = 7'b0001000,
    PH_UNARY = 7'b0010000,
    PH_REG   = 7'b0100000,
    PH_ESC   = 7'b1000000
  } phase_t;

  // Sequencer of the shared datapath
  typedef enum logic [8:0] {
    S_READY = 9'b000000001,
    S_REQ   = 9'b000000010,
    S_KSRCH = 9'b000000100,
    S_MAP   = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_NORM  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_SIGN  = 9'b010000000,
    S_FIX   = 9'b100000000
  } seq_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [12:0] count;
    logic        last;
  } res_t;

  // Run order J for a run index
  function automatic logic [3:0] run_order(input logic [4:0] idx);
    logic [3:0] j;
    case (idx) inside
      [5'd0:5'd3]:   j = 4'd0;
      [5'd4:5'd7]:   j = 4'd1;
      [5'd8:5'd11]:  j = 4'd2;
      [5'd12:5'd15]: j = 4'd3;
      [5'd16:5'd17]: j = 4'd4;
      [5'd18:5'd19]: j = 4'd5;
      [5'd20:5'd21]: j = 4'd6;
      [5'd22:5'd23]: j = 4'd7;
      default:       j = 4'(idx - 5'd16);
    endcase
    return j;
  endfunction

endpackage

[sv/jrmd_if.sv]
// Valid/ready channel interfaces for decoder items and results.
interface jrmd_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        bit_req;
  logic [15:0] run_value;
  logic [12:0] columns_left;
  logic [15:0] above_value;

  modport source(output valid, operation, bit_req, run_value, columns_left, above_value,
                 input ready);
  modport sink(input valid, operation, bit_req, run_value, columns_left, above_value,
               output ready);
endinterface

interface jrmd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] value;
  logic [12:0] count;
  logic        last;

  modport source(output valid, kind, value, count, last, input ready);
  modport sink(input valid, kind, value, count, last, output ready);
endinterface

[sv/jpegls_run_mode_decoder_top.sv]
// Run-mode decoder: bit-serial run scan, k search, Golomb decode and modular reconstruction.
// Start, clear and run/remainder/code bits act when taken; a request is queued in S_REQ.
// A neighbour item starts the shift-compare k search (S_KSRCH), with k <= 31.
// The last code bit runs map, multiply, normalise, modulo (restoring divider), sign, fix.
// Results leave through a 3-entry queue; an item is taken while at most one result waits.
// Reset (rst, synchronous) sets the configuration defaults, statistics and an idle phase.
`include "jpegls_run_mode_decoder_top_assert.svh"

module jpegls_run_mode_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [jrmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jrmd_pkg::CFG_W-1:0]      cfg_data,
  jrmd_item_if.sink                       item,
  jrmd_result_if.source                   result
);

  // configuration
  logic [7:0]  near;
  logic [15:0] maxval;
  logic [16:0] rng;
  logic [6:0]  limit;
  logic [4:0]  qbpp;
  logic [7:0]  rthr;
  logic [10:0] a_init;

  // run state and statistics
  logic [4:0]  run_index, previous_run_index;
  logic [31:0] error_sum [2];
  logic [7:0]  occurrences [2];
  logic [7:0]  negative_count [2];
  jrmd_pkg::phase_t phase;
  jrmd_pkg::seq_t   seq;
  logic [5:0]  bits_pending;
  logic [15:0] partial_count;
  logic [15:0] held_run_value, held_above;
  logic [12:0] remaining_columns;
  logic [6:0]  unary_zeros;
  logic [16:0] code_value;
  logic [4:0]  golomb_k;
  logic        interrupt_type;

  // datapath registers
  logic [38:0] ksh;
  logic [32:0] temp;
  logic        err_neg;
  logic [16:0] mag;
  logic [8:0]  scale;
  logic [25:0] m;
  logic signed [26:0] rx;
  logic [25:0] dq, rem;
  logic [4:0]  dcnt;
  logic signed [27:0] rres;

  // result queue
  jrmd_pkg::res_t q [3];
  logic [1:0] wp, rp, cnt;

  logic        accept, pop, push;
  jrmd_pkg::res_t push_res;
  logic [3:0]  j, jp;
  logic [15:0] fill_r;
  logic        run_fits, run_last;
  logic [15:0] pc_shift, pc_eff, rc_m1, req_cnt;
  logic [5:0]  bp_dec;
  logic [16:0] code_sh, uz_sh;
  logic signed [8:0] thresh;
  logic        t_in;
  logic        t;
  logic [16:0] em;
  logic [7:0]  n_t, nn_t;
  logic        map_c, neg_c;
  logic [16:0] mag_c;
  logic [25:0] sc_mag;
  logic [15:0] pred;
  logic        flip;
  logic [26:0] rem_sh;
  logic signed [28:0] radj;
  logic [15:0] sample;
  logic [7:0]  nn_inc, occ_h;
  logic [31:0] es_add;
  logic        halve;

  assign accept      = item.valid & item.ready;
  assign pop         = result.valid & result.ready;
  assign item.ready  = (seq == jrmd_pkg::S_READY) && (cnt <= 2'd1);
  assign result.valid = (cnt != 2'd0);
  assign result.kind  = q[rp].kind;
  assign result.value = q[rp].value;
  assign result.count = q[rp].count;
  assign result.last  = q[rp].last;

  // Run scan and remainder arithmetic
  always_comb begin
    j        = jrmd_pkg::run_order(run_index);
    jp       = jrmd_pkg::run_order(previous_run_index);
    fill_r   = 16'd1 << j;
    run_fits = {3'b0, remaining_columns} >= fill_r;
    run_last = {3'b0, remaining_columns} == fill_r;
    pc_shift = {partial_count[14:0], item.bit_req};
    bp_dec   = (bits_pending != 6'd0) ? bits_pending - 6'd1 : 6'd0;
    pc_eff   = (phase == jrmd_pkg::PH_REM) ? pc_shift : 16'd0;
    rc_m1    = {3'b0, remaining_columns - 13'd1};
    req_cnt  = (remaining_columns != 13'd0 && pc_eff > rc_m1) ? rc_m1 : pc_eff;
    code_sh  = {code_value[15:0], item.bit_req};
    uz_sh    = 17'(unary_zeros) << golomb_k;
    thresh   = $signed({2'b0, limit}) - $signed({5'b0, jp}) - 9'sd2
               - $signed({4'b0, qbpp});
    t_in     = (held_run_value == item.above_value);
  end

  // Error unmapping and statistics
  always_comb begin
    t      = interrupt_type;
    em     = code_value;
    n_t    = occurrences[t];
    nn_t   = negative_count[t];
    if (em[0]) begin
      map_c = !t;
      mag_c = 17'(({1'b0, em} + 18'd1) >> 1);
    end else if (t) begin
      map_c = 1'b1;
      mag_c = 17'(({1'b0, em} + 18'd2) >> 1);
    end else begin
      map_c = 1'b0;
      mag_c = {1'b0, em[16:1]};
    end
    neg_c = (golomb_k == 5'd0 && !map_c && {nn_t, 1'b0} < {1'b0, n_t}) ||
            (map_c && {nn_t, 1'b0} >= {1'b0, n_t}) ||
            (map_c && golomb_k != 5'd0);
    sc_mag = {9'b0, mag} * {17'b0, scale};
    pred   = t ? held_run_value : held_above;
    flip   = err_neg ^ (!t && held_above < held_run_value);
    rem_sh = {rem, dq[25]};
    nn_inc = err_neg ? nn_t + 8'd1 : nn_t;
    es_add = error_sum[t] + 32'(({1'b0, em} + 18'd1 - {17'b0, t}) >> 1);
    halve  = (n_t == rthr);
    occ_h  = halve ? {1'b0, n_t[7:1]} : n_t;
  end

  // Modular wrap and clamp of the reconstructed sample
  always_comb begin
    radj = 29'(rres);
    if (m != 26'd0) begin
      if (radj < -$signed({21'b0, near}))
        radj = radj + $signed({3'b0, m});
      else if (radj > $signed({13'b0, maxval}) + $signed({21'b0, near}))
        radj = radj - $signed({3'b0, m});
    end
    if (radj < 29'sd0)                          sample = 16'd0;
    else if (radj > $signed({13'b0, maxval}))   sample = maxval;
    else                                        sample = radj[15:0];
  end

  // Result to enqueue this cycle
  always_comb begin
    push     = 1'b0;
    push_res = '{kind: jrmd_pkg::KIND_FILL, value: held_run_value,
                 count: req_cnt[12:0], last: 1'b0};
    if (accept && item.operation == jrmd_pkg::OP_BIT) begin
      if (phase == jrmd_pkg::PH_RUN) begin
        if (item.bit_req) begin
          push = 1'b1;
          push_res.count = run_fits ? fill_r[12:0] : remaining_columns;
          push_res.last  = run_fits ? run_last : 1'b1;
        end else begin
          push = (j == 4'd0);
        end
      end else if (phase == jrmd_pkg::PH_REM) begin
        push = (bp_dec == 6'd0);
      end
    end else if (seq == jrmd_pkg::S_REQ) begin
      push = 1'b1;
      push_res = '{kind: jrmd_pkg::KIND_REQ, value: 16'd0, count: 13'd0, last: 1'b0};
    end else if (seq == jrmd_pkg::S_FIX) begin
      push = 1'b1;
      push_res = '{kind: jrmd_pkg::KIND_SAMPLE, value: sample, count: 13'd1, last: 1'b1};
    end
  end

  // Result queue: write at wp, read at rp
  always_ff @(posedge clk) begin
    if (push) q[wp] <= push_res;
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= (wp == 2'd2) ? 2'd0 : wp + 2'd1;
      if (pop)  rp <= (rp == 2'd2) ? 2'd0 : rp + 2'd1;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      near   <= 8'd0;
      maxval <= 16'd255;
      rng    <= 17'd256;
      limit  <= 7'd32;
      qbpp   <= 5'd8;
      rthr   <= 8'd64;
      a_init <= 11'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        jrmd_pkg::REG_NEAR:   near   <= cfg_data[7:0];
        jrmd_pkg::REG_MAXVAL: maxval <= cfg_data[15:0];
        jrmd_pkg::REG_RANGE:  rng    <= cfg_data[16:0];
        jrmd_pkg::REG_LIMIT:  limit  <= cfg_data[6:0];
        jrmd_pkg::REG_QBPP:   qbpp   <= cfg_data[4:0];
        jrmd_pkg::REG_RTHR:   rthr   <= cfg_data[7:0];
        jrmd_pkg::REG_AINIT:  a_init <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Datapath payload: no reset needed
  always_ff @(posedge clk) begin
    case (seq)
      jrmd_pkg::S_MAP: begin
        err_neg <= neg_c && (mag_c != 17'd0);
        mag     <= mag_c;
        m       <= {9'b0, rng} * {17'b0, scale};
      end
      jrmd_pkg::S_MUL: begin
        rx <= flip ? $signed({11'b0, pred}) - $signed({1'b0, sc_mag})
                   : $signed({11'b0, pred}) + $signed({1'b0, sc_mag});
      end
      jrmd_pkg::S_NORM: begin
        rres <= 28'(rx);
        dq   <= rx[26] ? 26'(-rx) : rx[25:0];
        rem  <= 26'd0;
        dcnt <= 5'd25;
      end
      jrmd_pkg::S_DIV: begin
        rem  <= (rem_sh >= {1'b0, m}) ? 26'(rem_sh - {1'b0, m}) : rem_sh[25:0];
        dq   <= {dq[24:0], 1'b0};
        dcnt <= dcnt - 5'd1;
      end
      jrmd_pkg::S_SIGN: begin
        rres <= rx[26] ? -$signed({2'b0, rem}) : $signed({2'b0, rem});
      end
      default: ;
    endcase
    if (seq == jrmd_pkg::S_READY) scale <= {near, 1'b1};
  end

  // Sequencer, phase and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      seq                <= jrmd_pkg::S_READY;
      phase              <= jrmd_pkg::PH_IDLE;
      run_index          <= 5'd0;
      previous_run_index <= 5'd0;
      for (int c = 0; c < 2; c++) begin
        error_sum[c]      <= 32'd4;
        occurrences[c]    <= 8'd1;
        negative_count[c] <= 8'd0;
      end
      bits_pending      <= 6'd0;
      partial_count     <= 16'd0;
      held_run_value    <= 16'd0;
      held_above        <= 16'd0;
      remaining_columns <= 13'd0;
      unary_zeros       <= 7'd0;
      code_value        <= 17'd0;
      golomb_k          <= 5'd0;
      interrupt_type    <= 1'b0;
      ksh               <= 39'd0;
      temp              <= 33'd0;
    end else begin
      case (seq)
        jrmd_pkg::S_READY: begin
          if (accept) begin
            case (item.operation)
              jrmd_pkg::OP_START: begin
                held_run_value <= item.run_value;
                if (item.columns_left > 13'(jrmd_pkg::LINE_MAX))
                  remaining_columns <= 13'(jrmd_pkg::LINE_MAX);
                else if (item.columns_left == 13'd0)
                  remaining_columns <= 13'd1;
                else
                  remaining_columns <= item.columns_left;
                partial_count <= 16'd0;
                bits_pending  <= 6'd0;
                unary_zeros   <= 7'd0;
                code_value    <= 17'd0;
                phase         <= jrmd_pkg::PH_RUN;
              end
              jrmd_pkg::OP_CLEAR: begin
                for (int c = 0; c < 2; c++) begin
                  error_sum[c]      <= {21'b0, a_init};
                  occurrences[c]    <= 8'd1;
                  negative_count[c] <= 8'd0;
                end
                run_index          <= 5'd0;
                previous_run_index <= 5'd0;
              end
              jrmd_pkg::OP_ABOVE: begin
                // start the k search for the interruption sample
                if (phase == jrmd_pkg::PH_WAIT) begin
                  held_above     <= item.above_value;
                  interrupt_type <= t_in;
                  temp <= t_in ? {1'b0, error_sum[1]} + {26'b0, occurrences[1][7:1]}
                               : {1'b0, error_sum[0]};
                  ksh      <= {31'b0, occurrences[t_in]};
                  golomb_k <= 5'd0;
                  seq      <= jrmd_pkg::S_KSRCH;
                end
              end
              default: begin
                case (phase)
                  jrmd_pkg::PH_RUN: begin
                    if (item.bit_req) begin
                      if (run_fits) begin
                        remaining_columns <= remaining_columns - fill_r[12:0];
                        if (run_index < 5'd31) begin
                          previous_run_index <= run_index;
                          run_index          <= run_index + 5'd1;
                        end
                        if (run_last) phase <= jrmd_pkg::PH_IDLE;
                      end else begin
                        remaining_columns <= 13'd0;
                        phase             <= jrmd_pkg::PH_IDLE;
                      end
                    end else begin
                      previous_run_index <= run_index;
                      if (run_index != 5'd0) run_index <= run_index - 5'd1;
                      partial_count <= 16'd0;
                      bits_pending  <= {2'b0, j};
                      if (j == 4'd0) begin
                        remaining_columns <= remaining_columns - req_cnt[12:0];
                        phase <= jrmd_pkg::PH_WAIT;
                        seq   <= jrmd_pkg::S_REQ;
                      end else begin
                        phase <= jrmd_pkg::PH_REM;
                      end
                    end
                  end
                  jrmd_pkg::PH_REM: begin
                    partial_count <= pc_shift;
                    bits_pending  <= bp_dec;
                    if (bp_dec == 6'd0) begin
                      remaining_columns <= remaining_columns - req_cnt[12:0];
                      phase <= jrmd_pkg::PH_WAIT;
                      seq   <= jrmd_pkg::S_REQ;
                    end
                  end
                  jrmd_pkg::PH_UNARY: begin
                    if (!item.bit_req) begin
                      if (unary_zeros < 7'd127) unary_zeros <= unary_zeros + 7'd1;
                    end else if ($signed({2'b0, unary_zeros}) < thresh) begin
                      phase        <= jrmd_pkg::PH_REG;
                      bits_pending <= {1'b0, golomb_k};
                      // the unary part is added once the k low bits are in
                      code_value   <= (golomb_k == 5'd0) ? uz_sh : 17'd0;
                      if (golomb_k == 5'd0) seq <= jrmd_pkg::S_MAP;
                    end else begin
                      phase        <= jrmd_pkg::PH_ESC;
                      bits_pending <= {1'b0, qbpp};
                      code_value   <= (qbpp == 5'd0) ? 17'd1 : 17'd0;
                      if (qbpp == 5'd0) seq <= jrmd_pkg::S_MAP;
                    end
                  end
                  jrmd_pkg::PH_REG, jrmd_pkg::PH_ESC: begin
                    bits_pending <= bp_dec;
                    if (bp_dec != 6'd0)
                      code_value <= code_sh;
                    else begin
                      code_value <= (phase == jrmd_pkg::PH_REG) ? uz_sh + code_sh
                                                                : code_sh + 17'd1;
                      seq <= jrmd_pkg::S_MAP;
                    end
                  end
                  default: ;
                endcase
              end
            endcase
          end
        end
        jrmd_pkg::S_REQ: seq <= jrmd_pkg::S_READY;
        jrmd_pkg::S_KSRCH: begin
          // one shift-compare step a cycle
          if (golomb_k < 5'd31 && ksh < {6'b0, temp}) begin
            golomb_k <= golomb_k + 5'd1;
            ksh      <= {ksh[37:0], 1'b0};
          end else begin
            unary_zeros <= 7'd0;
            code_value  <= 17'd0;
            phase       <= jrmd_pkg::PH_UNARY;
            seq         <= jrmd_pkg::S_READY;
          end
        end
        jrmd_pkg::S_MAP: seq <= jrmd_pkg::S_MUL;
        jrmd_pkg::S_MUL: seq <= jrmd_pkg::S_NORM;
        jrmd_pkg::S_NORM: seq <= (m == 26'd0) ? jrmd_pkg::S_FIX : jrmd_pkg::S_DIV;
        jrmd_pkg::S_DIV: if (dcnt == 5'd0) seq <= jrmd_pkg::S_SIGN;
        jrmd_pkg::S_SIGN: seq <= jrmd_pkg::S_FIX;
        jrmd_pkg::S_FIX: begin
          // update context statistics with halving
          error_sum[t]      <= halve ? {1'b0, es_add[31:1]} : es_add;
          negative_count[t] <= halve ? {1'b0, nn_inc[7:1]} : nn_inc;
          occurrences[t]    <= occ_h + 8'd1;
          phase             <= jrmd_pkg::PH_IDLE;
          seq               <= jrmd_pkg::S_READY;
        end
        default: seq <= jrmd_pkg::S_READY;
      endcase
    end
  end

  `JRMD_ASSERT_NOW(a_room_on_ready, clk, rst, item.ready, cnt <= 2'd1)
  `JRMD_ASSERT_NEXT(a_req_returns, clk, rst, seq == jrmd_pkg::S_REQ, seq == jrmd_pkg::S_READY && cnt != 2'd0)
  `JRMD_ASSERT_NEXT(a_div_ends, clk, rst, seq == jrmd_pkg::S_DIV && dcnt == 5'd0, seq == jrmd_pkg::S_SIGN)
  `JRMD_ASSERT_NEXT(a_sample_idles, clk, rst, seq == jrmd_pkg::S_FIX, phase == jrmd_pkg::PH_IDLE && cnt != 2'd0)

endmodule
